// File: rtl/rths_pkg.sv
// rths_pkg: shared types and constants for the rgb to hue/saturation block
// no dependencies; used by every module under rtl
package rths_pkg;

	// quotient bits resolved by the divider chain, one per cell (hue <= 60, sat <= 100)
	localparam int QUO_BITS = 7;
	localparam int HUE_BITS = 9;
	localparam int SAT_BITS = 7;
	// hue arithmetic before the wrap runs up to 420
	localparam int HUE_CALC_BITS = 10;

	localparam logic [HUE_CALC_BITS-1:0] HUE_BASE_RED   = 10'd360;
	localparam logic [HUE_CALC_BITS-1:0] HUE_BASE_GREEN = 10'd120;
	localparam logic [HUE_CALC_BITS-1:0] HUE_BASE_BLUE  = 10'd240;
	localparam logic [HUE_CALC_BITS-1:0] HUE_FULL_TURN  = 10'd360;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// control that rides along the chain with each beat
	typedef struct packed {
		logic    hue_ok;
		logic    sat_ok;
		logic    neg;
		sector_t sector;
	} ctl_t;

	typedef struct packed {
		logic                hue_valid;
		logic [HUE_BITS-1:0] hue_degrees;
		logic                sat_valid;
		logic [SAT_BITS-1:0] sat_percent;
	} res_t;

endpackage

// File: rtl/rgb_to_hue_saturation_top.sv
// rgb_to_hue_saturation_top: top level, prep stage, divider cell chain,
// finish stage and output skid; depends on rths_pkg and all rths_* modules

// Converts one RGB color per beat into hue (0 to 359 degrees, floored) and
// saturation (0 to 100 percent, floored) with validity flags. A new color is
// taken every clock while pix_stall is low; the result is registered through
// two prep stages, one divider cell per quotient bit (7 cells, both divisions
// side by side), one finish stage and the output register.
// The divider chain sets that rate: its cells each resolve one quotient bit
// and hand their partial remainders on every clock that the chain advances.
// Output stall is absorbed by a one-beat skid, so pix_stall is registered.
module rgb_to_hue_saturation_top #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pix_valid,
	output logic                    pix_stall,
	input  logic [CHANNEL_BITS-1:0] red,
	input  logic [CHANNEL_BITS-1:0] green,
	input  logic [CHANNEL_BITS-1:0] blue,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic                    hue_valid,
	output logic [rths_pkg::HUE_BITS-1:0] hue_degrees,
	output logic                    sat_valid,
	output logic [rths_pkg::SAT_BITS-1:0] sat_percent
);

	localparam int DW = CHANNEL_BITS + rths_pkg::QUO_BITS;
	localparam int QB = rths_pkg::QUO_BITS;

	logic adv;

	logic                    vld_c     [0:QB];
	rths_pkg::ctl_t          ctl_c     [0:QB];
	logic [DW-1:0]           hue_rem_c [0:QB];
	logic [QB-1:0]           hue_quo_c [0:QB];
	logic [CHANNEL_BITS-1:0] hue_div_c [0:QB];
	logic [DW-1:0]           sat_rem_c [0:QB];
	logic [QB-1:0]           sat_quo_c [0:QB];
	logic [CHANNEL_BITS-1:0] sat_div_c [0:QB];

	logic           fin_vld;
	rths_pkg::res_t fin_res;

	logic           out_vld_q, skid_vld_q;
	rths_pkg::res_t out_res_q, skid_res_q;

	// the whole chain moves while the skid is empty
	assign adv       = !skid_vld_q;
	assign pix_stall = skid_vld_q;

	rths_prep #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (pix_valid),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.out_vld (vld_c[0]),
		.out_ctl (ctl_c[0]),
		.hue_num (hue_rem_c[0]),
		.hue_div (hue_div_c[0]),
		.sat_num (sat_rem_c[0]),
		.sat_div (sat_div_c[0])
	);

	assign hue_quo_c[0] = '0;
	assign sat_quo_c[0] = '0;

	// cell k resolves quotient bit QB-1-k, msb first
	for (genvar k = 0; k < QB; k++) begin : g_cell
		rths_div_cell #(
			.CHANNEL_BITS(CHANNEL_BITS),
			.BIT_POS     (QB - 1 - k)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.in_vld      (vld_c[k]),
			.in_ctl      (ctl_c[k]),
			.in_hue_rem  (hue_rem_c[k]),
			.in_hue_quo  (hue_quo_c[k]),
			.in_hue_div  (hue_div_c[k]),
			.in_sat_rem  (sat_rem_c[k]),
			.in_sat_quo  (sat_quo_c[k]),
			.in_sat_div  (sat_div_c[k]),
			.out_vld     (vld_c[k+1]),
			.out_ctl     (ctl_c[k+1]),
			.out_hue_rem (hue_rem_c[k+1]),
			.out_hue_quo (hue_quo_c[k+1]),
			.out_hue_div (hue_div_c[k+1]),
			.out_sat_rem (sat_rem_c[k+1]),
			.out_sat_quo (sat_quo_c[k+1]),
			.out_sat_div (sat_div_c[k+1])
		);
	end

	rths_finish #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_vld     (vld_c[QB]),
		.in_ctl     (ctl_c[QB]),
		.in_hue_rem (hue_rem_c[QB]),
		.in_hue_quo (hue_quo_c[QB]),
		.in_sat_quo (sat_quo_c[QB]),
		.out_vld    (fin_vld),
		.out_res    (fin_res)
	);

	// output register with a one-beat skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !res_stall) begin
			out_vld_q  <= skid_vld_q ? 1'b1 : fin_vld;
			skid_vld_q <= 1'b0;
		end else if (fin_vld && adv) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !res_stall) begin
			out_res_q <= skid_vld_q ? skid_res_q : fin_res;
		end else if (fin_vld && adv) begin
			skid_res_q <= fin_res;
		end
	end

	assign res_valid   = out_vld_q;
	assign hue_valid   = out_res_q.hue_valid;
	assign hue_degrees = out_res_q.hue_degrees;
	assign sat_valid   = out_res_q.sat_valid;
	assign sat_percent = out_res_q.sat_percent;

endmodule

// File: rtl/rths_prep.sv
// rths_prep: front of the chain, max/min/sector pick then constant scaling
// of the two dividends; depends on rths_pkg
module rths_prep #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_vld,
	input  logic [CHANNEL_BITS-1:0] red,
	input  logic [CHANNEL_BITS-1:0] green,
	input  logic [CHANNEL_BITS-1:0] blue,
	output logic                    out_vld,
	output rths_pkg::ctl_t          out_ctl,
	output logic [CHANNEL_BITS+rths_pkg::QUO_BITS-1:0] hue_num,
	output logic [CHANNEL_BITS-1:0] hue_div,
	output logic [CHANNEL_BITS+rths_pkg::QUO_BITS-1:0] sat_num,
	output logic [CHANNEL_BITS-1:0] sat_div
);

	localparam int DW = CHANNEL_BITS + rths_pkg::QUO_BITS;

	logic [CHANNEL_BITS-1:0] mx, mn, p, q;
	rths_pkg::ctl_t          ctl;

	logic                    vld_s1, vld_s2;
	rths_pkg::ctl_t          ctl_s1, ctl_s2;
	logic [CHANNEL_BITS-1:0] num_s1, delta_s1, mx_s1;
	logic [CHANNEL_BITS-1:0] delta_s2, mx_s2;
	logic [DW-1:0]           hue_num_s2, sat_num_s2;

	// ties go to red, then green
	always_comb begin
		if (red >= green && red >= blue) begin
			ctl.sector = rths_pkg::SEC_RED;
			mx = red;
			p  = green;
			q  = blue;
		end else if (green >= blue) begin
			ctl.sector = rths_pkg::SEC_GREEN;
			mx = green;
			p  = blue;
			q  = red;
		end else begin
			ctl.sector = rths_pkg::SEC_BLUE;
			mx = blue;
			p  = red;
			q  = green;
		end
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
		ctl.neg    = (p < q);
		ctl.hue_ok = (mx != mn);
		ctl.sat_ok = (mx != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1   <= ctl;
			num_s1   <= ctl.neg ? (q - p) : (p - q);
			delta_s1 <= mx - mn;
			mx_s1    <= mx;

			ctl_s2     <= ctl_s1;
			delta_s2   <= delta_s1;
			mx_s2      <= mx_s1;
			// 60*n = 64n - 4n, 100*d = 64d + 32d + 4d
			hue_num_s2 <= (DW'(num_s1) << 6) - (DW'(num_s1) << 2);
			sat_num_s2 <= (DW'(delta_s1) << 6) + (DW'(delta_s1) << 5)
				+ (DW'(delta_s1) << 2);
		end
	end

	assign out_vld = vld_s2;
	assign out_ctl = ctl_s2;
	assign hue_num = hue_num_s2;
	assign hue_div = delta_s2;
	assign sat_num = sat_num_s2;
	assign sat_div = mx_s2;

endmodule

// File: rtl/rths_div_cell.sv
// rths_div_cell: one restoring-division step for hue and saturation,
// resolves quotient bit BIT_POS of each; depends on rths_pkg
module rths_div_cell #(
	parameter int CHANNEL_BITS = 8,
	parameter int BIT_POS      = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_vld,
	input  rths_pkg::ctl_t          in_ctl,
	input  logic [CHANNEL_BITS+rths_pkg::QUO_BITS-1:0] in_hue_rem,
	input  logic [rths_pkg::QUO_BITS-1:0]              in_hue_quo,
	input  logic [CHANNEL_BITS-1:0] in_hue_div,
	input  logic [CHANNEL_BITS+rths_pkg::QUO_BITS-1:0] in_sat_rem,
	input  logic [rths_pkg::QUO_BITS-1:0]              in_sat_quo,
	input  logic [CHANNEL_BITS-1:0] in_sat_div,
	output logic                    out_vld,
	output rths_pkg::ctl_t          out_ctl,
	output logic [CHANNEL_BITS+rths_pkg::QUO_BITS-1:0] out_hue_rem,
	output logic [rths_pkg::QUO_BITS-1:0]              out_hue_quo,
	output logic [CHANNEL_BITS-1:0] out_hue_div,
	output logic [CHANNEL_BITS+rths_pkg::QUO_BITS-1:0] out_sat_rem,
	output logic [rths_pkg::QUO_BITS-1:0]              out_sat_quo,
	output logic [CHANNEL_BITS-1:0] out_sat_div
);

	localparam int DW = CHANNEL_BITS + rths_pkg::QUO_BITS;

	logic [DW-1:0] hue_shift, sat_shift;
	logic          hue_take, sat_take;
	logic [rths_pkg::QUO_BITS-1:0] hue_quo_nxt, sat_quo_nxt;

	logic                          vld_s1;
	rths_pkg::ctl_t                ctl_s1;
	logic [DW-1:0]                 hue_rem_s1, sat_rem_s1;
	logic [rths_pkg::QUO_BITS-1:0] hue_quo_s1, sat_quo_s1;
	logic [CHANNEL_BITS-1:0]       hue_div_s1, sat_div_s1;

	assign hue_shift = DW'(in_hue_div) << BIT_POS;
	assign sat_shift = DW'(in_sat_div) << BIT_POS;
	assign hue_take  = (in_hue_rem >= hue_shift);
	assign sat_take  = (in_sat_rem >= sat_shift);

	always_comb begin
		hue_quo_nxt          = in_hue_quo;
		hue_quo_nxt[BIT_POS] = hue_take;
		sat_quo_nxt          = in_sat_quo;
		sat_quo_nxt[BIT_POS] = sat_take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1     <= in_ctl;
			hue_div_s1 <= in_hue_div;
			sat_div_s1 <= in_sat_div;
			hue_rem_s1 <= hue_take ? (in_hue_rem - hue_shift) : in_hue_rem;
			sat_rem_s1 <= sat_take ? (in_sat_rem - sat_shift) : in_sat_rem;
			hue_quo_s1 <= hue_quo_nxt;
			sat_quo_s1 <= sat_quo_nxt;
		end
	end

	assign out_vld     = vld_s1;
	assign out_ctl     = ctl_s1;
	assign out_hue_rem = hue_rem_s1;
	assign out_hue_quo = hue_quo_s1;
	assign out_hue_div = hue_div_s1;
	assign out_sat_rem = sat_rem_s1;
	assign out_sat_quo = sat_quo_s1;
	assign out_sat_div = sat_div_s1;

endmodule

// File: rtl/rths_finish.sv
// rths_finish: turns the chain's quotients into hue degrees and saturation,
// applies the sector offset, ceiling, wrap and validity; depends on rths_pkg
module rths_finish #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_vld,
	input  rths_pkg::ctl_t          in_ctl,
	input  logic [CHANNEL_BITS+rths_pkg::QUO_BITS-1:0] in_hue_rem,
	input  logic [rths_pkg::QUO_BITS-1:0]              in_hue_quo,
	input  logic [rths_pkg::QUO_BITS-1:0]              in_sat_quo,
	output logic                    out_vld,
	output rths_pkg::res_t          out_res
);

	localparam int HCB = rths_pkg::HUE_CALC_BITS;

	logic [HCB-1:0]   base, raw, wrapped;
	rths_pkg::res_t   res;

	logic             vld_s1;
	rths_pkg::res_t   res_s1;

	always_comb begin
		case (in_ctl.sector)
			rths_pkg::SEC_RED:   base = rths_pkg::HUE_BASE_RED;
			rths_pkg::SEC_GREEN: base = rths_pkg::HUE_BASE_GREEN;
			rths_pkg::SEC_BLUE:  base = rths_pkg::HUE_BASE_BLUE;
			default:             base = rths_pkg::HUE_BASE_RED;
		endcase
	end

	// negative offset takes the ceiling: one more when the division left a remainder
	assign raw = in_ctl.neg
		? (base - HCB'(in_hue_quo) - HCB'(in_hue_rem != '0))
		: (base + HCB'(in_hue_quo));
	assign wrapped = (raw >= rths_pkg::HUE_FULL_TURN) ? (raw - rths_pkg::HUE_FULL_TURN) : raw;

	always_comb begin
		res.hue_valid   = in_ctl.hue_ok && in_ctl.sat_ok;
		res.hue_degrees = res.hue_valid ? wrapped[rths_pkg::HUE_BITS-1:0] : '0;
		res.sat_valid   = in_ctl.sat_ok;
		res.sat_percent = in_ctl.sat_ok ? in_sat_quo : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s1 <= res;
		end
	end

	assign out_vld = vld_s1;
	assign out_res = res_s1;

endmodule
